@@ hdl/mer_pkg.sv @@
// Package for the midpoint ellipse rasterizer: sizes, codes, controller states
// and the command/status structs between controller and datapath. No dependencies.
package mer_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;
  localparam int PIX_W           = 14;
  localparam int COLOR_W         = 4;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd5;

  localparam int PIX_PER_STEP = 4;
  localparam int PIX_IDX_W    = $clog2(PIX_PER_STEP);
  localparam logic [PIX_IDX_W-1:0] PIX_LAST = PIX_IDX_W'(PIX_PER_STEP - 1);

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_INIT,
    ST_INIT2,
    ST_CHK,
    ST_M1,
    ST_M2,
    ST_SUM,
    ST_EMIT,
    ST_ADV
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SQ,
    OP_INIT,
    OP_INIT2,
    OP_M1,
    OP_M2,
    OP_SUM,
    OP_ADV
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic [PIX_IDX_W-1:0] pix_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic in_r2;
    logic y_zero;
    logic region_change;
  } dp_status_t;

endpackage

@@ hdl/mer_ifs.sv @@
// Stream interfaces of the ellipse rasterizer: request channel and pixel channel.
// Depends on mer_pkg for default sizes and pixel field widths.
interface mer_req_if #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;

  modport source (output valid, func, radius_x, radius_y, center_x, center_y, input ready);
  modport sink   (input valid, func, radius_x, radius_y, center_x, center_y, output ready);
endinterface

interface mer_pix_if ();
  import mer_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_x;
  logic signed [PIX_W-1:0] pixel_y;
  logic [COLOR_W-1:0]      color;
  logic                    group_last;
  logic                    ellipse_done;

  modport source (output valid, pixel_x, pixel_y, color, group_last, ellipse_done, input ready);
  modport sink   (input valid, pixel_x, pixel_y, color, group_last, ellipse_done, output ready);
endinterface

@@ hdl/mer_datapath.sv @@
// Datapath of the ellipse rasterizer: geometry registers, multipliers, decision
// update and pixel formation. Driven by mer_ctrl commands; depends on mer_pkg.
module mer_datapath #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mer_pkg::dp_cmd_t                cmd,
  output mer_pkg::dp_status_t             status,
  input  logic [RADIUS_BITS-1:0]          radius_x,
  input  logic [RADIUS_BITS-1:0]          radius_y,
  input  logic [COORD_BITS-1:0]           center_x,
  input  logic [COORD_BITS-1:0]           center_y,
  input  logic                            cfg_wr_en,
  input  logic [mer_pkg::COLOR_W-1:0]     cfg_wr_data,
  output logic signed [mer_pkg::PIX_W-1:0] pixel_x,
  output logic signed [mer_pkg::PIX_W-1:0] pixel_y,
  output logic [mer_pkg::COLOR_W-1:0]     color
);
  import mer_pkg::*;

  localparam int R  = RADIUS_BITS;
  localparam int SW = 3 * R + 4;
  localparam int DW = (4 * R + 8 > 64) ? 64 : 4 * R + 8;
  localparam int QW = 2 * R + 4;

  logic [R-1:0]          rx_l;
  logic [R-1:0]          ry_l;
  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [2*R-1:0]        rx2;
  logic [2*R-1:0]        ry2;
  logic [R:0]            cur_x;
  logic signed [R+1:0]   cur_y;
  logic signed [SW-1:0]  sx;
  logic signed [SW-1:0]  sy;
  logic [DW-1:0]         decision;
  logic [DW-1:0]         p0;
  logic [DW-1:0]         p1;
  logic [DW-1:0]         p2;
  logic                  in_r2;

  // products, each registered before any further use
  logic [2*R-1:0]        rx_sq_c;
  logic [2*R-1:0]        ry_sq_c;
  logic [3*R-1:0]        rx2_ry_c;
  logic [R+1:0]          tx;
  logic signed [R+1:0]   ty;
  logic [QW-1:0]         tx_sq_c;
  logic signed [QW-1:0]  ty_sq_c;
  logic [4*R-1:0]        rr_c;
  logic [4*R+3:0]        ma_c;
  logic [4*R+3:0]        mb_c;

  assign rx_sq_c  = rx_l * rx_l;
  assign ry_sq_c  = ry_l * ry_l;
  assign rx2_ry_c = rx2 * ry_l;
  assign tx       = {cur_x, 1'b1};
  assign ty       = cur_y - (R + 2)'(1);
  assign tx_sq_c  = tx * tx;
  assign ty_sq_c  = ty * ty;
  assign rr_c     = rx2 * ry2;
  assign ma_c     = ry2 * p0[QW-1:0];
  assign mb_c     = rx2 * p1[QW-1:0];

  // step update terms
  logic signed [SW-1:0] sx_inc;
  logic signed [SW-1:0] sy_dec;
  logic [DW-1:0]        f_sxi;
  logic [DW-1:0]        f_syd;
  logic [DW-1:0]        f_rx2;
  logic [DW-1:0]        f_ry2;
  logic                 dec_neg;
  logic                 dec_pos;

  assign sx_inc  = sx + SW'({ry2, 1'b0});
  assign sy_dec  = sy - SW'({rx2, 1'b0});
  assign f_sxi   = DW'(sx_inc) << 2;
  assign f_syd   = DW'(sy_dec) << 2;
  assign f_rx2   = DW'({rx2, 2'b00});
  assign f_ry2   = DW'({ry2, 2'b00});
  assign dec_neg = decision[DW-1];
  assign dec_pos = !dec_neg && (decision != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_r2 <= 1'b0;
      color <= COLOR_RESET;
    end else begin
      if (cfg_wr_en) begin
        color <= cfg_wr_data;
      end
      case (cmd.op)
        OP_LOAD: begin
          rx_l  <= radius_x;
          ry_l  <= radius_y;
          cx    <= center_x;
          cy    <= center_y;
          cur_x <= '0;
          cur_y <= (R + 2)'(radius_y);
          sx    <= '0;
          in_r2 <= 1'b0;
        end
        OP_SQ: begin
          rx2 <= rx_sq_c;
          ry2 <= ry_sq_c;
        end
        OP_INIT: begin
          p0 <= DW'(rx2_ry_c);
        end
        OP_INIT2: begin
          sy       <= SW'({p0[3*R-1:0], 1'b0});
          decision <= f_ry2 - (p0 << 2) + DW'(rx2);
        end
        OP_M1: begin
          in_r2 <= 1'b1;
          p0    <= DW'(tx_sq_c);
          p1    <= DW'(unsigned'(ty_sq_c));
          p2    <= DW'(rr_c);
        end
        OP_M2: begin
          p0 <= DW'(ma_c);
          p1 <= DW'(mb_c);
        end
        OP_SUM: begin
          decision <= p0 + (p1 << 2) - (p2 << 2);
        end
        OP_ADV: begin
          if (!in_r2) begin
            cur_x <= cur_x + 1'b1;
            sx    <= sx_inc;
            if (dec_neg) begin
              decision <= decision + f_sxi + f_ry2;
            end else begin
              cur_y    <= cur_y - (R + 2)'(1);
              sy       <= sy_dec;
              decision <= decision + f_sxi - f_syd + f_ry2;
            end
          end else begin
            cur_y <= cur_y - (R + 2)'(1);
            sy    <= sy_dec;
            if (dec_pos) begin
              decision <= decision + f_rx2 - f_syd;
            end else begin
              cur_x    <= cur_x + 1'b1;
              sx       <= sx_inc;
              decision <= decision + f_sxi - f_syd + f_rx2;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.in_r2         = in_r2;
  assign status.y_zero        = (cur_y == '0);
  assign status.region_change = !in_r2 && !(sx < sy);

  // quadrant select: bit 0 mirrors x, bit 1 mirrors y
  logic [PIX_W-1:0] cxw;
  logic [PIX_W-1:0] cyw;
  logic [PIX_W-1:0] pxw;
  logic [PIX_W-1:0] pyw;

  assign cxw = PIX_W'(cx);
  assign cyw = PIX_W'(cy);
  assign pxw = PIX_W'(cur_x);
  assign pyw = PIX_W'(cur_y);

  assign pixel_x = $signed(cxw + (cmd.pix_idx[0] ? -pxw : pxw));
  assign pixel_y = $signed(cyw + (cmd.pix_idx[1] ? -pyw : pyw));

endmodule

@@ hdl/mer_ctrl.sv @@
// Controller of the ellipse rasterizer: sequences start, pixel output, advance
// and region change through mer_datapath commands. Depends on mer_pkg.
module mer_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_func,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                group_last,
  output logic                ellipse_done,
  output mer_pkg::dp_cmd_t    cmd,
  input  mer_pkg::dp_status_t status
);
  import mer_pkg::*;

  state_t               state;
  state_t               state_next;
  logic                 active;
  logic [PIX_IDX_W-1:0] pix_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      active  <= 1'b0;
      pix_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_valid && in_func == FUNC_START) begin
        active <= 1'b1;
      end else if (state == ST_ADV && status.in_r2 && status.y_zero) begin
        active <= 1'b0;
      end
      if (state == ST_EMIT && out_ready) begin
        pix_idx <= pix_idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_START) begin
            state_next = ST_SQ;
          end else if (active) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQ:    state_next = ST_INIT;
      ST_INIT:  state_next = ST_INIT2;
      ST_INIT2: state_next = ST_CHK;
      ST_CHK:   state_next = status.region_change ? ST_M1 : ST_IDLE;
      ST_M1:    state_next = ST_M2;
      ST_M2:    state_next = ST_SUM;
      ST_SUM:   state_next = ST_IDLE;
      ST_EMIT: begin
        if (out_ready && pix_idx == PIX_LAST) begin
          state_next = ST_ADV;
        end
      end
      // region two checks no boundary after the advance
      ST_ADV:   state_next = status.in_r2 ? ST_IDLE : ST_CHK;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op      = OP_NOP;
    cmd.pix_idx = pix_idx;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_func == FUNC_START) begin
          cmd.op = OP_LOAD;
        end
      end
      ST_SQ:    cmd.op = OP_SQ;
      ST_INIT:  cmd.op = OP_INIT;
      ST_INIT2: cmd.op = OP_INIT2;
      ST_M1:    cmd.op = OP_M1;
      ST_M2:    cmd.op = OP_M2;
      ST_SUM:   cmd.op = OP_SUM;
      ST_EMIT:  out_valid = 1'b1;
      ST_ADV:   cmd.op = OP_ADV;
      default: begin
      end
    endcase
  end

  // last step of region two is the one whose advance takes y below zero
  assign group_last   = (pix_idx == PIX_LAST);
  assign ellipse_done = group_last && status.in_r2 && status.y_zero;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request and pixel channels active together");

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(pix_idx))
    else $error("pixel index moved while stalled");

  a_emit_active: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> active)
    else $error("pixel emitted while no ellipse is active");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV && status.in_r2 && status.y_zero) |=> (!active && state == ST_IDLE))
    else $error("final step did not end the ellipse");

endmodule

@@ hdl/midpoint_ellipse_rasterizer.sv @@
// Midpoint ellipse rasterizer, top level: controller and datapath, one pixel a cycle
// while pix.ready holds. Start request: load on accept, SQ, INIT, INIT2, a boundary
// check, then idle; entering region two at once adds M1, M2 and SUM; no pixel.
// Step request: accept, four pixels (longer under output stall), the advance, and in
// region one a boundary check (M1, M2, SUM on region change). One request at a time.
// Reset (synchronous, active high): idle, no ellipse active, pixel color 5.
module midpoint_ellipse_rasterizer #(
  parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  mer_req_if.sink                     req,
  mer_pix_if.source                   pix,
  input  logic                        cfg_wr_en,
  input  logic [mer_pkg::COLOR_W-1:0] cfg_wr_data
);
  import mer_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mer_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .in_func      (req.func),
    .out_valid    (pix.valid),
    .out_ready    (pix.ready),
    .group_last   (pix.group_last),
    .ellipse_done (pix.ellipse_done),
    .cmd          (cmd),
    .status       (status)
  );

  mer_datapath #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .radius_x    (req.radius_x),
    .radius_y    (req.radius_y),
    .center_x    (req.center_x),
    .center_y    (req.center_y),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .pixel_x     (pix.pixel_x),
    .pixel_y     (pix.pixel_y),
    .color       (pix.color)
  );

endmodule

@@ sim/midpoint_ellipse_rasterizer_tb.sv @@
// Self-checking bench for midpoint_ellipse_rasterizer: directed and random requests
// checked pixel by pixel against a behavioral ellipse tracer. Depends on mer_pkg, mer_ifs.
module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;

  localparam int RB = RADIUS_BITS_DEF;
  localparam int CB = COORD_BITS_DEF;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int SEND_IDLE [4] = '{0, 53, 0, 26};
  localparam int RECV_STALL [4] = '{0, 0, 53, 26};

  typedef struct packed {
    logic          func;
    logic [RB-1:0] rx;
    logic [RB-1:0] ry;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
  } request_t;

  typedef struct packed {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               done;
  } pixel_t;

  // typed rows: n_pix pixels at column x, the first two on row y_hi, the others on y_lo
  typedef struct packed {
    request_t         rq;
    logic             typed;
    logic [2:0]       n_pix;
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y_hi;
    logic [PIX_W-1:0] y_lo;
    logic             done;
  } directed_row_t;

  localparam directed_row_t DIRECTED [25] = '{
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_START, 0, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 4, 0, 0, 0, 1},
    '{'{FUNC_STEP, 1023, 1023, 4095, 4095}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_START, 0, 0, 4095, 4095}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 4, 4095, 4095, 4095, 1},
    '{'{FUNC_START, 1023, 1023, 4095, 4095}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 4, 4095, 5118, 3072, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_START, 1023, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 4, 0, 0, 0, 1},
    '{'{FUNC_START, 0, 3, 2000, 1}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_START, 3, 2, 10, 10}, 1, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0},
    '{'{FUNC_STEP, 0, 0, 0, 0}, 0, 0, 0, 0, 0, 0}
  };

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic [COLOR_W-1:0] cfg_wr_data;

  mer_req_if req_ch ();
  mer_pix_if pix_ch ();

  midpoint_ellipse_rasterizer u_dut (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .pix        (pix_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // tracer state: current point, slope terms, decision value scaled by four
  longint             pt_x = 0;
  longint             pt_y = 0;
  longint             grow_x = 0;
  longint             grow_y = 0;
  logic [63:0]        dec_acc = '0;
  logic [63:0]        rx_sq = '0;
  logic [63:0]        ry_sq = '0;
  logic [CB-1:0]      org_x = '0;
  logic [CB-1:0]      org_y = '0;
  logic               in_r2 = 1'b0;
  logic               drawing = 1'b0;
  logic [COLOR_W-1:0] color_reg = COLOR_RESET;

  pixel_t step_pixels [PIX_PER_STEP];
  pixel_t pending_pixels [$];
  int     n_errors = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void enter_region_check();
    logic [63:0] tx, ty;
    if (!in_r2 && !(grow_x < grow_y)) begin
      tx = 64'(2 * pt_x + 1);
      ty = 64'(pt_y - 1);
      in_r2 = 1'b1;
      dec_acc = ry_sq * tx * tx + 64'd4 * rx_sq * ty * ty - 64'd4 * rx_sq * ry_sq;
    end
  endfunction

  function automatic pixel_t mirror_pixel(longint dx, longint dy, logic last, logic done);
    pixel_t p;
    p.x = PIX_W'(longint'(org_x) + dx);
    p.y = PIX_W'(longint'(org_y) + dy);
    p.color = color_reg;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // Advance the tracer by one request; fill step_pixels and return their count.
  function automatic int rasterize_request(request_t rq);
    logic [63:0] rx, ry;
    longint      px, py;
    logic        positive, finished;
    if (rq.func == FUNC_START) begin
      rx = 64'(rq.rx);
      ry = 64'(rq.ry);
      org_x = rq.cx;
      org_y = rq.cy;
      rx_sq = rx * rx;
      ry_sq = ry * ry;
      pt_x = 0;
      pt_y = longint'(ry);
      grow_x = 0;
      grow_y = longint'(64'd2 * rx_sq * ry);
      dec_acc = 64'd4 * ry_sq - 64'd4 * rx_sq * ry + rx_sq;
      in_r2 = 1'b0;
      drawing = 1'b1;
      enter_region_check();
      return 0;
    end
    if (!drawing) return 0;
    px = pt_x;
    py = pt_y;
    finished = 1'b0;
    if (!in_r2) begin
      pt_x++;
      grow_x += longint'(64'd2 * ry_sq);
      if (dec_acc[63]) begin
        dec_acc += 64'd4 * grow_x + 64'd4 * ry_sq;
      end else begin
        pt_y--;
        grow_y -= longint'(64'd2 * rx_sq);
        dec_acc += 64'd4 * grow_x - 64'd4 * grow_y + 64'd4 * ry_sq;
      end
      enter_region_check();
    end else begin
      positive = !dec_acc[63] && dec_acc != 0;
      pt_y--;
      grow_y -= longint'(64'd2 * rx_sq);
      if (positive) begin
        dec_acc += 64'd4 * rx_sq - 64'd4 * grow_y;
      end else begin
        pt_x++;
        grow_x += longint'(64'd2 * ry_sq);
        dec_acc += 64'd4 * grow_x - 64'd4 * grow_y + 64'd4 * rx_sq;
      end
      if (pt_y < 0) begin
        finished = 1'b1;
        drawing = 1'b0;
      end
    end
    step_pixels[0] = mirror_pixel(px, py, 1'b0, 1'b0);
    step_pixels[1] = mirror_pixel(-px, py, 1'b0, 1'b0);
    step_pixels[2] = mirror_pixel(px, -py, 1'b0, 1'b0);
    step_pixels[3] = mirror_pixel(-px, -py, 1'b1, finished);
    return PIX_PER_STEP;
  endfunction

  function automatic string pixel_text(pixel_t p);
    return $sformatf("x=%0d y=%0d color=%0d last=%0b done=%0b",
                     $signed(p.x), $signed(p.y), p.color, p.last, p.done);
  endfunction

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      got = '{pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.color, pix_ch.group_last,
              pix_ch.ellipse_done};
      if (pending_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) $display("unexpected pixel: %s", pixel_text(got));
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("pixel mismatch: expected %s, got %s", pixel_text(want), pixel_text(got));
        end
      end
    end
  end

  always @(posedge clk)
    pix_ch.ready <= !rst && ($urandom_range(0, 99) >= stall_pct);

  task automatic send_request(request_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.func     <= rq.func;
    req_ch.radius_x <= rq.rx;
    req_ch.radius_y <= rq.ry;
    req_ch.center_x <= rq.cx;
    req_ch.center_y <= rq.cy;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  function automatic void queue_step_pixels(int n);
    for (int k = 0; k < n; k++) pending_pixels.push_back(step_pixels[k]);
  endfunction

  task automatic issue_request(request_t rq);
    send_request(rq);
    queue_step_pixels(rasterize_request(rq));
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // Write the color only once the block has drained and finished its advance.
  task automatic set_color(logic [COLOR_W-1:0] value);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    color_reg = value;
  endtask

  function automatic request_t step_request();
    return '{FUNC_STEP, RB'($urandom_range(0, 1023)), RB'($urandom_range(0, 1023)),
             CB'($urandom_range(0, 4095)), CB'($urandom_range(0, 4095))};
  endfunction

  // Mostly complete small ellipses; some large ones cut short by the next start.
  task automatic run_random_phase(int target);
    int       counted, steps_left;
    logic     paused;
    request_t rq;
    counted = 0;
    paused = 1'b0;
    while (counted < target) begin
      rq = '{FUNC_START, RB'(0), RB'(0), CB'($urandom_range(0, 4095)),
             CB'($urandom_range(0, 4095))};
      if ($urandom_range(0, 99) < 20) begin
        rq.rx = RB'($urandom_range(0, 1023));
        rq.ry = RB'($urandom_range(0, 1023));
        steps_left = $urandom_range(1, 6);
      end else begin
        rq.rx = RB'($urandom_range(0, 10));
        rq.ry = RB'($urandom_range(0, 10));
        steps_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 1 << 30;
      end
      issue_request(rq);
      counted++;
      while (drawing && steps_left > 0) begin
        issue_request(step_request());
        counted++;
        steps_left--;
      end
      // step on an idle block: must produce nothing
      if (!drawing && $urandom_range(0, 3) == 0) begin
        issue_request(step_request());
        counted++;
      end
      if (!paused && counted >= target / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    directed_row_t row;
    int            n;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_START;
    req_ch.radius_x = '0;
    req_ch.radius_y = '0;
    req_ch.center_x = '0;
    req_ch.center_y = '0;
    pix_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      send_request(row.rq);
      n = rasterize_request(row.rq);
      if (row.typed) begin
        for (int k = 0; k < row.n_pix; k++)
          pending_pixels.push_back(pixel_t'{row.x, (k < 2) ? row.y_hi : row.y_lo,
                                            COLOR_RESET, k == 3, (k == 3) && row.done});
      end else begin
        queue_step_pixels(n);
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_color(4'hF);
        1: set_color(4'h0);
        2: set_color(COLOR_W'($urandom_range(1, 14)));
        default: set_color(COLOR_RESET);
      endcase
      send_idle_pct = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      run_random_phase(ITEMS_PER_PHASE);
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/mer_pkg.sv
hdl/mer_ifs.sv
hdl/mer_datapath.sv
hdl/mer_ctrl.sv
hdl/midpoint_ellipse_rasterizer.sv
sim/midpoint_ellipse_rasterizer_tb.sv
